### sv/wsd_pkg.sv
// Package for the websocket frame deframer: parse phases, event codes and result type.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HEAD0   = 3'd0,
        PH_HEAD1   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_CLOSE = 2'd2
    } event_t;

    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [2:0] EXT16_LAST    = 3'd1;
    localparam logic [2:0] EXT64_LAST    = 3'd7;
    localparam logic [2:0] MASK_KEY_LAST = 3'd3;
    localparam logic [3:0] OPCODE_CLOSE  = 4'd8;

    typedef struct packed {
        logic [7:0] out_byte;
        event_t     event_kind;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
    } result_t;

endpackage

`default_nettype wire

### sv/wsd_parser.sv
// Header parser and payload unmasker: one byte per fire, at most one result.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire logic [7:0] rx_byte,
    output logic         res_valid,
    output result_t      res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  left_reg, left_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] mask_reg, mask_next;
    logic [1:0]  pos_reg, pos_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] shift_in;
    logic [7:0]  key;

    assign shift_in = {shift_reg[55:0], rx_byte};

    always_comb
    begin
        case (pos_reg)
            2'd0:    key = mask_reg[31:24];
            2'd1:    key = mask_reg[23:16];
            2'd2:    key = mask_reg[15:8];
            default: key = mask_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        mask_next   = mask_reg;
        pos_next    = pos_reg;
        opcode_next = opcode_reg;
        case (phase_reg)
            PH_HEAD0:
            begin
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HEAD1;
            end
            PH_HEAD1:
            begin
                if (!rx_byte[7] || opcode_reg == OPCODE_CLOSE)
                begin
                    phase_next = PH_CLOSED;
                end
                else
                begin
                    shift_next = '0;
                    mask_next  = '0;
                    if (rx_byte[6:0] < LEN_EXT16)
                    begin
                        remain_next = {57'd0, rx_byte[6:0]};
                        left_next   = MASK_KEY_LAST;
                        phase_next  = PH_MASK;
                    end
                    else
                    begin
                        left_next  = (rx_byte[6:0] == LEN_EXT16) ? EXT16_LAST : EXT64_LAST;
                        phase_next = PH_EXTLEN;
                    end
                end
            end
            PH_EXTLEN:
            begin
                shift_next = shift_in;
                if (left_reg == 3'd0)
                begin
                    remain_next = shift_in;
                    left_next   = MASK_KEY_LAST;
                    phase_next  = PH_MASK;
                end
                else
                begin
                    left_next = left_reg - 3'd1;
                end
            end
            PH_MASK:
            begin
                mask_next = {mask_reg[23:0], rx_byte};
                if (left_reg == 3'd0)
                begin
                    pos_next   = 2'd0;
                    phase_next = (remain_reg == 64'd0) ? PH_HEAD0 : PH_PAYLOAD;
                end
                else
                begin
                    left_next = left_reg - 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                pos_next    = pos_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                if (remain_reg == 64'd1)
                begin
                    phase_next = PH_HEAD0;
                end
            end
            default:
            begin
                phase_next = PH_CLOSED;
            end
        endcase
    end

    always_comb
    begin
        res_valid         = 1'b0;
        res.out_byte      = 8'd0;
        res.event_kind    = EV_DATA;
        res.frame_opcode  = opcode_reg;
        res.last_of_frame = 1'b0;
        case (phase_reg)
            PH_HEAD1:
            begin
                if (!rx_byte[7] || opcode_reg == OPCODE_CLOSE)
                begin
                    res_valid      = fire;
                    res.event_kind = EV_CLOSE;
                end
            end
            PH_MASK:
            begin
                if (left_reg == 3'd0 && remain_reg == 64'd0)
                begin
                    res_valid         = fire;
                    res.event_kind    = EV_EMPTY;
                    res.last_of_frame = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid         = fire;
                res.out_byte      = rx_byte ^ key;
                res.last_of_frame = (remain_reg == 64'd1);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD0;
            left_reg   <= '0;
            shift_reg  <= '0;
            remain_reg <= '0;
            mask_reg   <= '0;
            pos_reg    <= '0;
            opcode_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            mask_reg   <= mask_next;
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
        end
    end

endmodule

`default_nettype wire

### sv/websocket_frame_deframer.sv
// Top level of the websocket frame deframer: input register, parser, two-entry result buffer.
//
//  channel  | dir | tdata               | tuser                         | tlast
//  s_axis   | in  | [7:0] rx_byte       | -                             | -
//  m_axis   | out | [7:0] out_byte      | [1:0] event_kind [5:2] opcode | last_of_frame
//
// One byte per cycle sustained while the result buffer accepts; a byte is captured in the input
// register and any result, formed by the parser from that register, is written into the result
// buffer. Reset returns the parser to header byte zero and empties both buffers.
// The input register holds while the two-entry result buffer is full and not drained.
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [5:0]      m_tuser,   // [1:0] event_kind, [5:2] frame_opcode
    output logic            m_tlast    // last_of_frame
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       pop;
    logic       push;
    logic       res_valid;
    result_t    res;
    result_t    buf_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign pop      = m_tvalid && m_tready;
    assign fire     = in_valid_reg && (cnt_reg != 2'd2 || pop);
    assign s_tready = !in_valid_reg || fire;
    assign push     = res_valid;

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_mem[rd_ptr_reg].out_byte;
    assign m_tuser  = {buf_mem[rd_ptr_reg].frame_opcode, buf_mem[rd_ptr_reg].event_kind};
    assign m_tlast  = buf_mem[rd_ptr_reg].last_of_frame;

endmodule

`default_nettype wire
